[hdl/dmwc_pkg.sv]
package dmwc_pkg;

    // Field widths of one request and one result.
    localparam int ADDRESS_W          = 32;
    localparam int COMMAND_W          = 1;
    localparam int BYTE_OFFSET_W      = 5;
    localparam int BLOCK_NUMBER_W     = 27;
    localparam int LINE_INDEX_W       = 7;
    localparam int TAG_VALUE_W        = 20;
    localparam int BYTES_W            = 6;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W          = 40;
    localparam int M_TDATA_W          = 96;

    // Command codes.
    localparam logic CMD_READ         = 1'b0;
    localparam logic CMD_WRITE        = 1'b1;

    // Controller to datapath.
    typedef struct packed {
        logic capture;  // latch the request and launch the tag read
        logic commit;   // resolve the lookup, update the line and load the result
    } t_ctrl_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free; // the result register can take a new result this cycle
    } t_ctrl_sts;

endpackage

[hdl/direct_mapped_writeback_cache_tags_top.sv]
// A taken request is latched with its tag RAM read, then compared and loaded into the result
// register that drives m_axis. A new request is taken only after the previous lookup has
// committed; one waiting result still lets the next request in, which then waits for m_axis.
// Reset (i_rst_n low, synchronous) clears all valid and dirty bits at once; no clearing
// pass is needed. Tag RAM contents are left undefined and are used only for valid lines.
module direct_mapped_writeback_cache_tags_top #(
    parameter int NUM_LINES   = 128,  // number of cache lines, a power of two
    parameter int BLOCK_BYTES = 32    // bytes per line, a power of two
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // Memory reference request.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] address, [32] command (0 read, 1 write), [39:33] zero
    input  logic [dmwc_pkg::S_TDATA_W-1:0]    s_axis_tdata,

    // Lookup result.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [4:0] byte_offset, [31:5] block_number, [38:32] line_index, [58:39] tag_value,
    // [59] miss, [60] replaced, [61] fill_read, [67:62] fill_bytes, [68] write_back,
    // [74:69] write_back_bytes, [94:75] victim_tag, [95] zero
    output logic [dmwc_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    // The controller sequences each request through capture and lookup; the datapath
    // holds the tag RAM, the valid and dirty bits and the result register.
    dmwc_pkg::t_ctrl_cmd w_cmd;
    dmwc_pkg::t_ctrl_sts w_sts;

    dmwc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    dmwc_dp #(
        .NUM_LINES   (NUM_LINES),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res_data  (m_axis_tdata)
    );

endmodule

[hdl/dmwc_ram.sv]
module dmwc_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/dmwc_ctrl.sv]
module dmwc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  dmwc_pkg::t_ctrl_sts i_sts,
    output dmwc_pkg::t_ctrl_cmd o_cmd
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    t_state r_state;
    logic   r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_req_valid && r_ready) begin
                        r_state <= ST_LOOKUP;
                        r_ready <= 1'b0;
                    end else begin
                        r_ready <= 1'b1;
                    end
                end
                ST_LOOKUP: begin
                    if (i_sts.out_free) begin
                        r_state <= ST_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_ready <= 1'b0;
                end
            endcase
        end
    end

    assign o_req_ready    = r_ready;
    assign o_cmd.capture  = i_req_valid && r_ready;
    assign o_cmd.commit   = (r_state == ST_LOOKUP) && i_sts.out_free;

    // A request is taken only while no lookup is in flight.
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_state == ST_IDLE))
        else $error("request port ready during a lookup");

endmodule

[hdl/dmwc_dp.sv]
module dmwc_dp #(
    parameter int NUM_LINES   = 128,
    parameter int BLOCK_BYTES = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [dmwc_pkg::S_TDATA_W-1:0]       i_req_data,
    input  dmwc_pkg::t_ctrl_cmd                  i_cmd,
    output dmwc_pkg::t_ctrl_sts                  o_sts,
    output logic                                 o_res_valid,
    input  logic                                 i_res_ready,
    output logic [dmwc_pkg::M_TDATA_W-1:0]       o_res_data
);

    localparam int ADDR_W = dmwc_pkg::ADDRESS_W;
    localparam int OFF_W  = $clog2(BLOCK_BYTES);
    localparam int IDX_W  = $clog2(NUM_LINES);
    localparam int TAG_W  = ADDR_W - OFF_W - IDX_W;
    localparam logic [dmwc_pkg::BYTES_W-1:0] BLOCK_BYTES_F = dmwc_pkg::BYTES_W'(BLOCK_BYTES);
    localparam int PAD_W  = dmwc_pkg::M_TDATA_W - 95;

    logic [ADDR_W-1:0]      r_addr;
    logic                   r_cmd;
    logic [NUM_LINES-1:0]   r_valid;
    logic [NUM_LINES-1:0]   r_dirty;
    logic                   r_out_valid;
    logic [dmwc_pkg::M_TDATA_W-1:0] r_out_data;

    logic [TAG_W-1:0]       w_old_tag;
    logic [IDX_W-1:0]       w_idx;
    logic [TAG_W-1:0]       w_tag;
    logic [ADDR_W-1:0]      w_offset32;
    logic [ADDR_W-1:0]      w_block32;
    logic [ADDR_W-1:0]      w_idx32;
    logic [ADDR_W-1:0]      w_tag32;
    logic [ADDR_W-1:0]      w_victim32;
    logic                   w_line_valid;
    logic                   w_miss;
    logic                   w_repl;
    logic                   w_wb;
    logic [dmwc_pkg::M_TDATA_W-1:0] n_out_data;

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr <= i_req_data[ADDR_W-1:0];
            r_cmd  <= i_req_data[ADDR_W];
        end
    end

    dmwc_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_LINES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && w_miss),
        .i_waddr (w_idx),
        .i_wdata (w_tag),
        .i_re    (i_cmd.capture),
        .i_raddr (i_req_data[OFF_W +: IDX_W]),
        .o_rdata (w_old_tag)
    );

    // Address split and lookup.
    assign w_idx        = r_addr[OFF_W +: IDX_W];
    assign w_tag        = r_addr[ADDR_W-1 -: TAG_W];
    assign w_offset32   = r_addr & ADDR_W'(BLOCK_BYTES - 1);
    assign w_block32    = r_addr >> OFF_W;
    assign w_idx32      = ADDR_W'(w_idx);
    assign w_tag32      = ADDR_W'(w_tag);
    assign w_line_valid = r_valid[w_idx];
    assign w_miss       = !w_line_valid || (w_old_tag != w_tag);
    assign w_repl       = w_line_valid && (w_old_tag != w_tag);
    assign w_wb         = w_repl && r_dirty[w_idx];
    assign w_victim32   = w_repl ? ADDR_W'(w_old_tag) : '0;

    assign n_out_data = {
        {PAD_W{1'b0}},
        w_victim32[dmwc_pkg::TAG_VALUE_W-1:0],
        (w_wb ? BLOCK_BYTES_F : '0),
        w_wb,
        (w_miss ? BLOCK_BYTES_F : '0),
        w_miss,
        w_repl,
        w_miss,
        w_tag32[dmwc_pkg::TAG_VALUE_W-1:0],
        w_idx32[dmwc_pkg::LINE_INDEX_W-1:0],
        w_block32[dmwc_pkg::BLOCK_NUMBER_W-1:0],
        w_offset32[dmwc_pkg::BYTE_OFFSET_W-1:0]
    };

    // Line state: a miss allocates the line clean for a read and dirty for a write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
        end else if (i_cmd.commit) begin
            r_valid[w_idx] <= 1'b1;
            if (w_miss) begin
                r_dirty[w_idx] <= (r_cmd == dmwc_pkg::CMD_WRITE);
            end else if (r_cmd == dmwc_pkg::CMD_WRITE) begin
                r_dirty[w_idx] <= 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_res_ready;
    assign o_res_valid    = r_out_valid;
    assign o_res_data     = r_out_data;

    // The looked-up line is valid once its lookup has committed.
    a_line_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_valid[w_idx])
        else $error("line not valid after lookup");

    // A write always leaves its line dirty.
    a_write_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_cmd == dmwc_pkg::CMD_WRITE)) |=> r_dirty[w_idx])
        else $error("line not dirty after write");

    // A write-back only comes with an eviction, and an eviction only with a miss.
    a_wb_needs_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> ((!w_wb || w_repl) && (!w_repl || w_miss)))
        else $error("write-back or eviction without a miss");

endmodule
